// ----- src/sws_pkg.sv -----
// Shared constants, types and codes for the stack with second-largest query.
package sws_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int DATA_W      = 32;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W       = $clog2(STACK_DEPTH);

  typedef logic signed [DATA_W-1:0] data_t;

  localparam logic [1:0] MODE_PUSH   = 2'd0;
  localparam logic [1:0] MODE_POP    = 2'd1;
  localparam logic [1:0] MODE_PEEK   = 2'd2;
  localparam logic [1:0] MODE_SECOND = 2'd3;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_EMPTY = 3'd1;
  localparam logic [2:0] ST_FULL  = 3'd2;
  localparam logic [2:0] ST_FEW   = 3'd3;
  localparam logic [2:0] ST_NONE  = 3'd4;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_RIGHT,
    CELL_LEFT
  } cell_op_t;

  typedef struct packed {
    logic  have;
    logic  found;
    data_t big;
    data_t second;
  } trk_t;

endpackage

// ----- src/sws_cell.sv -----
// One stack cell: holds one entry and shifts toward either neighbor.
module sws_cell
  import sws_pkg::*;
(
  input  logic     clk,
  input  cell_op_t op,
  input  data_t    from_lo,
  input  data_t    from_hi,
  output data_t    value
);

  data_t value_r;
  data_t value_nxt;

  always_comb begin
    unique case (op)
      CELL_RIGHT: value_nxt = from_lo;
      CELL_LEFT:  value_nxt = from_hi;
      default:    value_nxt = value_r;
    endcase
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign value = value_r;

endmodule

// ----- src/sws_tracker.sv -----
// Running largest and second-largest distinct value over a stream of samples.
module sws_tracker
  import sws_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  clear,
  input  logic  sample,
  input  data_t value,
  output trk_t  trk_nxt
);

  trk_t trk_r;

  always_comb begin
    trk_nxt = trk_r;
    if (clear) begin
      trk_nxt.have  = 1'b0;
      trk_nxt.found = 1'b0;
    end else if (sample) begin
      if (!trk_r.have) begin
        trk_nxt.have = 1'b1;
        trk_nxt.big  = value;
      end else if (value > trk_r.big) begin
        // The old maximum is now the best value strictly below the new one.
        trk_nxt.second = trk_r.big;
        trk_nxt.found  = 1'b1;
        trk_nxt.big    = value;
      end else if (value < trk_r.big && (!trk_r.found || value > trk_r.second)) begin
        trk_nxt.second = value;
        trk_nxt.found  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trk_r.have  <= 1'b0;
      trk_r.found <= 1'b0;
    end else begin
      trk_r.have  <= trk_nxt.have;
      trk_r.found <= trk_nxt.found;
    end
    trk_r.big    <= trk_nxt.big;
    trk_r.second <= trk_nxt.second;
  end

endmodule

// ----- src/stack_with_second_largest.sv -----
// Top level of the LIFO stack with a second-largest distinct value query.
//
// Usage: a command is transferred at a rising clock edge where start is high
// and busy is low. in_mode selects push, pop, peek or the second-largest
// query; in_push_value is used by push only. Every command gives exactly one
// result, shown on out_status and out_data_out for one cycle while out_valid
// is high. The receiver cannot stall, so each result must be taken as shown.
//
// Timing: push, pop, peek and a query on fewer than two entries answer in
// the cycle after the transfer, and busy stays low, so such commands can be
// issued every cycle. A query on two or more entries rotates the whole cell
// chain once around while the scan unit watches the head cell; its result
// appears in the cycle after the last rotation step, and busy is high
// throughout the rotation.
//
// Storage is a row of cells: push shifts every cell one place away from the
// head, pop shifts every cell toward it, and the query rotates the chain so
// that the original order is restored when the scan ends.
//
// Reset empties the stack and drops any pending result; cell contents are
// left as they are since only entries below the count are ever read.
module stack_with_second_largest
  import sws_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_mode,
  input  data_t       in_push_value,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output data_t       out_data_out
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  logic             state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [2:0]       out_status_r, out_status_nxt;
  data_t            out_data_r, out_data_nxt;

  cell_op_t cell_op;
  data_t    cell_val [STACK_DEPTH];

  logic trk_clear;
  logic trk_sample;
  trk_t trk_nxt;

  logic accept;
  logic scan_last;

  assign accept    = start && (state_r == S_IDLE);
  assign scan_last = (idx_r == IDX_W'(STACK_DEPTH - 1));

  // The chain of cells: the head cell (index zero) is the top of the stack.
  // The tail wraps to the head so that a left shift doubles as a rotation.
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    data_t lo;
    data_t hi;
    if (i == 0) begin : g_head
      assign lo = in_push_value;
    end else begin : g_mid_lo
      assign lo = cell_val[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_tail
      assign hi = cell_val[0];
    end else begin : g_mid_hi
      assign hi = cell_val[i+1];
    end
    sws_cell u_cell (
      .clk     (clk),
      .op      (cell_op),
      .from_lo (lo),
      .from_hi (hi),
      .value   (cell_val[i])
    );
  end

  // During a scan, step k shows original entry k at the head cell.
  sws_tracker u_tracker (
    .clk     (clk),
    .rst_n   (rst_n),
    .clear   (trk_clear),
    .sample  (trk_sample),
    .value   (cell_val[0]),
    .trk_nxt (trk_nxt)
  );

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_data_nxt   = out_data_r;
    cell_op        = CELL_HOLD;
    trk_clear      = 1'b0;
    trk_sample     = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_status_nxt = ST_OK;
          out_data_nxt   = '0;
          unique case (in_mode)
            MODE_PUSH: begin
              out_valid_nxt = 1'b1;
              if (count_r == CNT_W'(STACK_DEPTH)) begin
                out_status_nxt = ST_FULL;
              end else begin
                cell_op   = CELL_RIGHT;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            MODE_POP, MODE_PEEK: begin
              out_valid_nxt = 1'b1;
              if (count_r == '0) begin
                out_status_nxt = ST_EMPTY;
              end else begin
                out_data_nxt = cell_val[0];
                if (in_mode == MODE_POP) begin
                  cell_op   = CELL_LEFT;
                  count_nxt = count_r - CNT_W'(1);
                end
              end
            end
            default: begin
              if (count_r < CNT_W'(2)) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_FEW;
              end else begin
                trk_clear = 1'b1;
                idx_nxt   = '0;
                state_nxt = S_SCAN;
              end
            end
          endcase
        end
      end
      default: begin
        // Only the cells below the count hold entries; the rest rotate past
        // without being sampled.
        cell_op    = CELL_LEFT;
        trk_sample = (CNT_W'(idx_r) < count_r);
        idx_nxt    = idx_r + IDX_W'(1);
        if (scan_last) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          if (trk_nxt.found) begin
            out_status_nxt = ST_OK;
            out_data_nxt   = trk_nxt.second;
          end else begin
            out_status_nxt = ST_NONE;
            out_data_nxt   = '0;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_status_r <= out_status_nxt;
    out_data_r   <= out_data_nxt;
  end

  assign busy         = (state_r == S_SCAN);
  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_data_out = out_data_r;

  // A scan only runs on a stack that holds at least two entries.
  a_scan_needs_two: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> (count_r >= CNT_W'(2)))
    else $error("scan running on fewer than two entries");

  // The entry count never passes the depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(STACK_DEPTH))
    else $error("entry count beyond depth");

  // The rotation leaves the stack contents count untouched.
  a_scan_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> $stable(count_r))
    else $error("entry count changed during scan");

  // A non-query transfer answers in the very next cycle.
  a_quick_answer: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_mode != MODE_SECOND)) |=> out_valid)
    else $error("missing result after push, pop or peek");

  // A query that starts a scan gives no result until the scan ends.
  a_scan_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_mode == MODE_SECOND) && (count_r >= CNT_W'(2))) |=> (busy && !out_valid))
    else $error("result shown while scan starts");

endmodule
